@@ sv/rsm_pkg.sv @@
package rsm_pkg;

    // register map, word index = paddr / 4
    localparam logic [2:0] REG_RESOURCE_COUNT = 3'd0;
    localparam logic [2:0] REG_INIT_R0        = 3'd1;
    localparam logic [2:0] REG_INIT_R3        = 3'd4;
    localparam int         INIT_REGS          = 4;

    localparam logic [2:0] RESET_RESOURCE_COUNT = 3'd1;
    localparam logic [7:0] RESET_UNITS_R0       = 8'd3;

    // command modes
    localparam logic [1:0] MODE_WAIT    = 2'd0;
    localparam logic [1:0] MODE_SIGNAL  = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_BLOCKED   = 3'd1;
    localparam logic [2:0] ST_SIGNALLED = 3'd2;
    localparam logic [2:0] ST_FINISH    = 3'd3;
    localparam logic [2:0] ST_RELEASED  = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    // one register write seen by the core
    typedef struct packed {
        logic       wr;
        logic [2:0] idx;
        logic [7:0] data;
    } t_cfg_wr;

endpackage

@@ sv/rsm_cfg.sv @@
module rsm_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output rsm_pkg::t_cfg_wr     o_cfg,
    output logic [2:0]           o_resource_count
);

    logic [2:0] r_resource_count;
    logic [7:0] r_init_units [rsm_pkg::INIT_REGS];
    logic [2:0] idx;
    logic [1:0] ui;
    logic       wr;
    logic       is_init;

    assign idx     = paddr[4:2];
    assign ui      = 2'(idx - rsm_pkg::REG_INIT_R0);
    assign wr      = psel && penable && pwrite;
    assign is_init = (idx >= rsm_pkg::REG_INIT_R0) && (idx <= rsm_pkg::REG_INIT_R3);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resource_count <= rsm_pkg::RESET_RESOURCE_COUNT;
            r_init_units[0]  <= rsm_pkg::RESET_UNITS_R0;
            for (int i = 1; i < rsm_pkg::INIT_REGS; i++) r_init_units[i] <= 8'd0;
        end else if (wr) begin
            if (idx == rsm_pkg::REG_RESOURCE_COUNT) r_resource_count <= pwdata[2:0];
            else if (is_init) r_init_units[ui] <= pwdata[7:0];
        end
    end

    always_comb begin
        if (idx == rsm_pkg::REG_RESOURCE_COUNT) prdata = {29'd0, r_resource_count};
        else if (is_init) prdata = {24'd0, r_init_units[ui]};
        else prdata = 32'd0;
    end

    assign o_cfg.wr         = wr;
    assign o_cfg.idx        = idx;
    assign o_cfg.data       = pwdata[7:0];
    assign o_resource_count = r_resource_count;

endmodule

@@ sv/resource_semaphore_manager_core.sv @@
// counting semaphore unit with a fifo wait queue per resource
// command channel: a word (i_mode, i_resource, i_process_id) is taken at a
//   rising edge with start high and busy low
// result channel: each result word sits on the o_ ports for one cycle with
//   o_valid high; o_last marks the final word of a command; the receiver
//   cannot stall, results are simply presented
// config: apb-style port, pready always high, resource_count at 0x0 and
//   initial_units_r0..r3 at 0x4..0x10; writing a unit count also loads the
//   available count of that resource
// wait and signal: one busy state (S_EXEC); the held-count and queue-head
//   memory reads issue at the accept edge, the busy cycle modifies and writes
//   back; the result shows in the cycle after the busy cycle, when the next
//   command may already be taken
// release-all: per resource S_RA_ISSUE and S_RA_LOAD read the held count, then
//   S_RA_FIFO and S_RA_UNIT per released waiter (queue memory read per pop), one
//   more such pass when units remain after the queue has emptied, then S_RA_DONE; each word is registered
// reset: queues empty, resource 0 holds RESET_UNITS_R0 units and the others none,
//   held tallies cleared through valid bits, no clearing pass needed
module resource_semaphore_manager_core #(
    parameter int NUM_RESOURCES = 4,
    parameter int MAX_PROCESSES = 16,
    parameter int QUEUE_DEPTH   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_resource,
    input  logic [3:0]  i_process_id,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic        o_woken_valid,
    output logic [3:0]  o_woken_pid,
    output logic [2:0]  o_resource_index,
    output logic [7:0]  o_available_after,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW     = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int CW     = $clog2(NUM_RESOURCES + 1);
    localparam int HA_W   = RW + 4;
    localparam int HDEPTH = NUM_RESOURCES * 16;
    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW     = $clog2(QUEUE_DEPTH + 1);
    localparam int SW     = FW + 1;
    localparam int FDEPTH = NUM_RESOURCES * QUEUE_DEPTH;
    localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_RA_ISSUE = 3'd2;
    localparam logic [2:0] S_RA_LOAD  = 3'd3;
    localparam logic [2:0] S_RA_FIFO  = 3'd4;
    localparam logic [2:0] S_RA_UNIT  = 3'd5;
    localparam logic [2:0] S_RA_DONE  = 3'd6;

    function automatic logic [7:0] inc_sat(input logic [7:0] v);
        return (v == 8'hff) ? v : 8'(v + 8'd1);
    endfunction

    function automatic logic [FA_W-1:0] faddr(input logic [RW-1:0] r, input logic [QW-1:0] s);
        return FA_W'(FA_W'(r) * FA_W'(QUEUE_DEPTH) + FA_W'(s));
    endfunction

    // config registers
    rsm_pkg::t_cfg_wr cfg;
    logic [2:0]       resource_count;

    rsm_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_cfg            (cfg),
        .o_resource_count (resource_count)
    );

    // resources in use = min(resource_count, NUM_RESOURCES)
    logic [CW-1:0] act;
    assign act = (32'(resource_count) < NUM_RESOURCES) ? CW'(resource_count)
                                                       : CW'(NUM_RESOURCES);

    // per-resource small state
    logic [7:0]    r_avail [NUM_RESOURCES];
    logic [QW-1:0] r_head  [NUM_RESOURCES];
    logic [FW-1:0] r_fill  [NUM_RESOURCES];

    // held tally memory, cleared through per-entry valid bits
    logic [7:0]        r_held_mem [HDEPTH];
    logic [HDEPTH-1:0] r_held_vld;
    logic [7:0]        r_held_rd;
    logic              r_held_rdv;

    // blocked queue memory
    logic [3:0] r_fifo_mem [FDEPTH];
    logic [3:0] r_fifo_rd;

    // command and walk registers
    logic [2:0]    r_state, n_state;
    logic [1:0]    r_mode;
    logic [2:0]    r_res;
    logic [3:0]    r_pid;
    logic [RW-1:0] r_q, n_q;
    logic [7:0]    r_cnt, n_cnt;

    // memory ports
    logic [HA_W-1:0] held_ra, hw_addr;
    logic            hw_en, hv_clr;
    logic [7:0]      hw_data;
    logic [FA_W-1:0] fifo_ra, fw_addr;
    logic            fw_en;

    // resource update
    logic          ru_en;
    logic [RW-1:0] ru_idx;
    logic [7:0]    ru_avail;
    logic [QW-1:0] ru_head;
    logic [FW-1:0] ru_fill;

    // result word
    logic       e_valid, e_wv, e_last;
    logic [2:0] e_status, e_ri;
    logic [3:0] e_wp;
    logic [7:0] e_av;

    // command decode helpers
    logic [RW-1:0] in_ri, ri, qi;
    logic          in_mode_ra, in_pid_ok;
    logic          known, pid_ok;
    logic [7:0]    a_cur, h_cur, a_q;
    logic [QW-1:0] hd_cur, hd_next, hd_q_next, push_slot;
    logic [FW-1:0] f_cur, f_q;
    logic [SW-1:0] push_sum;
    logic [8:0]    bulk_sum;
    logic          last_q;

    assign in_ri      = i_resource[RW-1:0];
    assign in_mode_ra = (i_mode == rsm_pkg::MODE_RELEASE);
    assign in_pid_ok  = 32'(i_process_id) < MAX_PROCESSES;

    assign ri      = r_res[RW-1:0];
    assign known   = 32'(r_res) < 32'(act);
    assign pid_ok  = 32'(r_pid) < MAX_PROCESSES;
    assign a_cur   = r_avail[ri];
    assign f_cur   = r_fill[ri];
    assign hd_cur  = r_head[ri];
    assign h_cur   = r_held_rdv ? r_held_rd : 8'd0;
    assign hd_next = (hd_cur == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(hd_cur + 1'b1);

    // tail slot = (head + fill) mod depth, sum stays below twice the depth
    assign push_sum  = SW'(hd_cur) + SW'(f_cur);
    assign push_slot = (32'(push_sum) >= QUEUE_DEPTH) ? QW'(push_sum - SW'(QUEUE_DEPTH))
                                                      : QW'(push_sum);

    assign qi        = r_q;
    assign a_q       = r_avail[qi];
    assign f_q       = r_fill[qi];
    assign hd_q_next = (r_head[qi] == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(r_head[qi] + 1'b1);
    assign bulk_sum  = {1'b0, a_q} + {1'b0, r_cnt};
    assign last_q    = (32'(r_q) + 1) >= 32'(act);

    always_comb begin
        n_state  = r_state;
        n_q      = r_q;
        n_cnt    = r_cnt;
        held_ra  = {ri, r_pid};
        fifo_ra  = faddr(ri, hd_cur);
        hw_en    = 1'b0;
        hv_clr   = 1'b0;
        hw_addr  = {ri, r_pid};
        hw_data  = 8'd0;
        fw_en    = 1'b0;
        fw_addr  = faddr(ri, push_slot);
        ru_en    = 1'b0;
        ru_idx   = ri;
        ru_avail = a_cur;
        ru_head  = hd_cur;
        ru_fill  = f_cur;
        e_valid  = 1'b0;
        e_status = rsm_pkg::ST_FINISH;
        e_wv     = 1'b0;
        e_wp     = 4'd0;
        e_ri     = r_res;
        e_av     = 8'd0;
        e_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                // reads issued at the accept edge, data used in the next state
                held_ra = {in_ri, i_process_id};
                fifo_ra = faddr(in_ri, r_head[in_ri]);
                if (start) begin
                    n_q = '0;
                    if (!in_mode_ra) n_state = S_EXEC;
                    else if (in_pid_ok && act != '0) n_state = S_RA_ISSUE;
                    else n_state = S_RA_DONE;
                end
            end
            S_EXEC: begin
                e_valid = 1'b1;
                e_av    = known ? a_cur : 8'd0;
                n_state = S_IDLE;
                if (known && pid_ok && r_mode == rsm_pkg::MODE_WAIT) begin
                    if (a_cur != 8'd0) begin
                        ru_en    = 1'b1;
                        ru_avail = 8'(a_cur - 8'd1);
                        hw_en    = 1'b1;
                        hw_data  = inc_sat(h_cur);
                        e_status = rsm_pkg::ST_GRANTED;
                        e_av     = ru_avail;
                    end else if (32'(f_cur) < QUEUE_DEPTH) begin
                        fw_en    = 1'b1;
                        ru_en    = 1'b1;
                        ru_fill  = FW'(f_cur + 1'b1);
                        e_status = rsm_pkg::ST_BLOCKED;
                    end else begin
                        e_status = rsm_pkg::ST_OVERFLOW;
                    end
                end else if (known && pid_ok && r_mode == rsm_pkg::MODE_SIGNAL
                             && h_cur != 8'd0) begin
                    hw_en    = 1'b1;
                    hw_data  = 8'(h_cur - 8'd1);
                    ru_en    = 1'b1;
                    ru_avail = inc_sat(a_cur);
                    e_status = rsm_pkg::ST_SIGNALLED;
                    e_av     = ru_avail;
                    if (f_cur != '0) begin
                        // head waiter goes to ready, unit stays free
                        ru_head = hd_next;
                        ru_fill = FW'(f_cur - 1'b1);
                        e_wv    = 1'b1;
                        e_wp    = r_fifo_rd;
                    end
                end
            end
            S_RA_ISSUE: begin
                held_ra = {qi, r_pid};
                n_state = S_RA_LOAD;
            end
            S_RA_LOAD: begin
                n_cnt   = h_cur;
                hv_clr  = 1'b1;
                hw_addr = {qi, r_pid};
                if (h_cur != 8'd0) n_state = S_RA_FIFO;
                else if (last_q) n_state = S_RA_DONE;
                else begin
                    n_q     = RW'(r_q + 1'b1);
                    n_state = S_RA_ISSUE;
                end
            end
            S_RA_FIFO: begin
                fifo_ra = faddr(qi, r_head[qi]);
                n_state = S_RA_UNIT;
            end
            S_RA_UNIT: begin
                ru_en   = 1'b1;
                ru_idx  = qi;
                ru_head = r_head[qi];
                ru_fill = f_q;
                if (f_q == '0) begin
                    // no waiters left: return the rest in one step
                    ru_avail = bulk_sum[8] ? 8'hff : bulk_sum[7:0];
                    n_cnt    = 8'd0;
                end else begin
                    ru_avail = inc_sat(a_q);
                    ru_head  = hd_q_next;
                    ru_fill  = FW'(f_q - 1'b1);
                    n_cnt    = 8'(r_cnt - 8'd1);
                    e_valid  = 1'b1;
                    e_status = rsm_pkg::ST_RELEASED;
                    e_wv     = 1'b1;
                    e_wp     = r_fifo_rd;
                    e_ri     = 3'(qi);
                    e_av     = ru_avail;
                    e_last   = 1'b0;
                end
                if (n_cnt != 8'd0) n_state = S_RA_FIFO;
                else if (last_q) n_state = S_RA_DONE;
                else begin
                    n_q     = RW'(r_q + 1'b1);
                    n_state = S_RA_ISSUE;
                end
            end
            S_RA_DONE: begin
                e_valid  = 1'b1;
                e_status = rsm_pkg::ST_DONE;
                e_ri     = 3'd0;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // memories
    always_ff @(posedge i_clk) begin
        r_held_rd <= r_held_mem[held_ra];
        if (hw_en) r_held_mem[hw_addr] <= hw_data;
    end

    always_ff @(posedge i_clk) begin
        r_fifo_rd <= r_fifo_mem[fifo_ra];
        if (fw_en) r_fifo_mem[fw_addr] <= r_pid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= '0;
            r_held_rdv <= 1'b0;
        end else begin
            r_held_rdv <= r_held_vld[held_ra];
            if (hw_en) r_held_vld[hw_addr] <= 1'b1;
            else if (hv_clr) r_held_vld[hw_addr] <= 1'b0;
        end
    end

    // control and per-resource state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q     <= '0;
            r_cnt   <= 8'd0;
            for (int i = 0; i < NUM_RESOURCES; i++) begin
                r_avail[i] <= (i == 0) ? rsm_pkg::RESET_UNITS_R0 : 8'd0;
                r_head[i]  <= '0;
                r_fill[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            r_cnt   <= n_cnt;
            if (ru_en) begin
                r_avail[ru_idx] <= ru_avail;
                r_head[ru_idx]  <= ru_head;
                r_fill[ru_idx]  <= ru_fill;
            end
            if (cfg.wr && cfg.idx >= rsm_pkg::REG_INIT_R0 && cfg.idx <= rsm_pkg::REG_INIT_R3
                && 32'(cfg.idx - rsm_pkg::REG_INIT_R0) < NUM_RESOURCES) begin
                r_avail[RW'(cfg.idx - rsm_pkg::REG_INIT_R0)] <= cfg.data;
            end
        end
    end

    // command word capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode <= i_mode;
            r_res  <= i_resource;
            r_pid  <= i_process_id;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= e_valid;
    end

    always_ff @(posedge i_clk) begin
        o_status          <= e_status;
        o_woken_valid     <= e_wv;
        o_woken_pid       <= e_wp;
        o_resource_index  <= e_ri;
        o_available_after <= e_av;
        o_last            <= e_last;
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not make the block busy");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final result while the walk has stopped");

    a_woken_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_woken_valid |->
            (o_status == rsm_pkg::ST_RELEASED || o_status == rsm_pkg::ST_SIGNALLED))
        else $error("woken pid on a result that releases no waiter");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == rsm_pkg::ST_DONE |-> o_last && !o_woken_valid)
        else $error("release done word is not final");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int NRES      = 4;
    localparam int NPROC     = 16;
    localparam int QDEPTH    = 8;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 20;

    // result word as seen on the output ports
    typedef struct packed {
        logic [2:0] status;
        logic       woken_valid;
        logic [3:0] woken_pid;
        logic [2:0] resource_index;
        logic [7:0] available_after;
        logic       last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [2:0]  i_resource;
    logic [3:0]  i_process_id;
    logic        o_valid;
    logic [2:0]  o_status;
    logic        o_woken_valid;
    logic [3:0]  o_woken_pid;
    logic [2:0]  o_resource_index;
    logic [7:0]  o_available_after;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    resource_semaphore_manager_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_resource(i_resource), .i_process_id(i_process_id),
        .o_valid(o_valid), .o_status(o_status), .o_woken_valid(o_woken_valid),
        .o_woken_pid(o_woken_pid), .o_resource_index(o_resource_index),
        .o_available_after(o_available_after), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state, mirrors the semaphore tables
    logic [2:0] sem_count;
    logic [7:0] sem_avail [NRES];
    logic [7:0] sem_held  [NRES][NPROC];
    logic [3:0] sem_queue [NRES][QDEPTH];
    logic [2:0] sem_head  [NRES];
    logic [3:0] sem_fill  [NRES];

    t_result expected_words [$];
    int      fail_count;
    int      idle_cycles;
    bit      timed_out;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function automatic int active_res();
        return (sem_count < NRES) ? sem_count : NRES;
    endfunction

    function automatic t_result mk(input logic [2:0] st, input logic wv,
                                   input logic [3:0] wp, input logic [2:0] ri,
                                   input logic [7:0] av, input logic lst);
        t_result w;
        w.status = st; w.woken_valid = wv; w.woken_pid = wp;
        w.resource_index = ri; w.available_after = av; w.last = lst;
        return w;
    endfunction

    function automatic logic [3:0] pop_waiter(input int r);
        logic [3:0] pid;
        pid = sem_queue[r][sem_head[r]];
        sem_head[r] = 3'((sem_head[r] + 1) % QDEPTH);
        sem_fill[r] = sem_fill[r] - 4'd1;
        return pid;
    endfunction

    // semaphore predictor: appends the expected result words of one command
    task automatic predict_semaphore(input logic [1:0] md, input logic [2:0] r,
                                     input logic [3:0] p);
        logic known;
        logic [3:0] wp;
        logic wv;
        int h;
        known = (r < active_res());
        if (md == rsm_pkg::MODE_RELEASE) begin
            for (int q = 0; q < active_res(); q++) begin
                for (h = sem_held[q][p]; h > 0; h--) begin
                    sem_avail[q] = sat_inc(sem_avail[q]);
                    if (sem_fill[q] > 0) begin
                        wp = pop_waiter(q);
                        expected_words.push_back(mk(rsm_pkg::ST_RELEASED, 1'b1, wp, q[2:0],
                                                    sem_avail[q], 1'b0));
                    end
                end
                sem_held[q][p] = 8'd0;
            end
            expected_words.push_back(mk(rsm_pkg::ST_DONE, 1'b0, 4'd0, 3'd0, 8'd0, 1'b1));
        end else if (md == 2'd3 || !known) begin
            expected_words.push_back(mk(rsm_pkg::ST_FINISH, 1'b0, 4'd0, r,
                                        known ? sem_avail[r] : 8'd0, 1'b1));
        end else if (md == rsm_pkg::MODE_WAIT) begin
            if (sem_avail[r] > 0) begin
                sem_avail[r]--;
                sem_held[r][p] = sat_inc(sem_held[r][p]);
                expected_words.push_back(mk(rsm_pkg::ST_GRANTED, 1'b0, 4'd0, r,
                                            sem_avail[r], 1'b1));
            end else if (sem_fill[r] < QDEPTH) begin
                sem_queue[r][(sem_head[r] + sem_fill[r]) % QDEPTH] = p;
                sem_fill[r]++;
                expected_words.push_back(mk(rsm_pkg::ST_BLOCKED, 1'b0, 4'd0, r,
                                            sem_avail[r], 1'b1));
            end else begin
                expected_words.push_back(mk(rsm_pkg::ST_OVERFLOW, 1'b0, 4'd0, r,
                                            sem_avail[r], 1'b1));
            end
        end else begin
            if (sem_held[r][p] == 0) begin
                expected_words.push_back(mk(rsm_pkg::ST_FINISH, 1'b0, 4'd0, r,
                                            sem_avail[r], 1'b1));
            end else begin
                wv = 1'b0;
                wp = 4'd0;
                sem_held[r][p]--;
                sem_avail[r] = sat_inc(sem_avail[r]);
                if (sem_fill[r] > 0) begin
                    wp = pop_waiter(r);
                    wv = 1'b1;
                end
                expected_words.push_back(mk(rsm_pkg::ST_SIGNALLED, wv, wp, r,
                                            sem_avail[r], 1'b1));
            end
        end
    endtask

    // mostly short gaps, now and then a long one; start drops only for a real gap
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        if (n != 0) start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // apb write, setup then access phase; predictor follows the register
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == rsm_pkg::REG_RESOURCE_COUNT) sem_count = val[2:0];
        else sem_avail[idx - rsm_pkg::REG_INIT_R0] = val;
    endtask

    // send one command word; start stays high until busy lets it in
    task automatic send_command(input logic [1:0] md, input logic [2:0] r,
                                input logic [3:0] p, input bit gaps);
        start <= 1'b1; i_mode <= md; i_resource <= r; i_process_id <= p;
        do @(posedge i_clk); while (busy);
        predict_semaphore(md, r, p);
        if (gaps) idle_gap();
    endtask

    // block idle: all words in and the tail of release-all walked out
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_words.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic configure(input logic [2:0] cnt, input logic [7:0] u0,
                             input logic [7:0] u1, input logic [7:0] u2,
                             input logic [7:0] u3);
        wait_drained();
        write_reg(rsm_pkg::REG_RESOURCE_COUNT, cnt);
        write_reg(rsm_pkg::REG_INIT_R0, u0);
        write_reg(rsm_pkg::REG_INIT_R0 + 3'd1, u1);
        write_reg(rsm_pkg::REG_INIT_R0 + 3'd2, u2);
        write_reg(rsm_pkg::REG_INIT_R3, u3);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // reset values: one resource with three units
    task automatic test_reset_defaults();
        for (int i = 0; i < 4; i++) send_command(rsm_pkg::MODE_WAIT, 3'd0, i[3:0], 1'b0);
        send_command(rsm_pkg::MODE_SIGNAL, 3'd1, 4'd0, 1'b0);
        send_command(rsm_pkg::MODE_RELEASE, 3'd0, 4'd0, 1'b0);
        send_command(rsm_pkg::MODE_RELEASE, 3'd0, 4'd2, 1'b0);
    endtask

    // fill a queue to overflow, then wake through signal and release-all
    task automatic test_queue_edges();
        configure(3'd7, 8'd1, 8'd0, 8'd255, 8'd0);
        send_command(rsm_pkg::MODE_WAIT, 3'd0, 4'd15, 1'b0);
        for (int i = 0; i < QDEPTH + 1; i++)
            send_command(rsm_pkg::MODE_WAIT, 3'd0, i[3:0], 1'b0);
        send_command(rsm_pkg::MODE_SIGNAL, 3'd0, 4'd15, 1'b0);
        send_command(rsm_pkg::MODE_SIGNAL, 3'd0, 4'd15, 1'b0);
        send_command(rsm_pkg::MODE_WAIT, 3'd2, 4'd3, 1'b0);
        send_command(rsm_pkg::MODE_SIGNAL, 3'd2, 4'd3, 1'b0);
        send_command(rsm_pkg::MODE_SIGNAL, 3'd2, 4'd3, 1'b0);
        send_command(2'd3, 3'd7, 4'd9, 1'b0);
        send_command(rsm_pkg::MODE_WAIT, 3'd5, 4'd0, 1'b0);
        send_command(rsm_pkg::MODE_WAIT, 3'd0, 4'd15, 1'b1);
        send_command(rsm_pkg::MODE_RELEASE, 3'd6, 4'd15, 1'b0);
    endtask

    // wait and signal at the top of the available count, then a wait with no resources in use
    task automatic test_saturation();
        configure(3'd4, 8'd255, 8'd0, 8'd0, 8'd0);
        send_command(rsm_pkg::MODE_WAIT, 3'd0, 4'd1, 1'b0);
        send_command(rsm_pkg::MODE_SIGNAL, 3'd0, 4'd1, 1'b0);
        configure(3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(rsm_pkg::MODE_WAIT, 3'd0, 4'd1, 1'b0);
    endtask

    // random mix; weighted to wait and signal so queues fill and drain
    task automatic test_random_mix(input int n_items);
        logic [1:0] md;
        logic [2:0] r;
        int sel;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 19);
            md = (sel < 9) ? rsm_pkg::MODE_WAIT : (sel < 17) ? rsm_pkg::MODE_SIGNAL :
                 (sel < 19) ? rsm_pkg::MODE_RELEASE : 2'd3;
            r = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(0, 3));
            send_command(md, r, 4'($urandom_range(0, 7) == 0 ? $urandom_range(0, 15)
                                                            : $urandom_range(0, 5)), 1'b1);
        end
    endtask

    // watchdog: cycles with no command accepted and no result word
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    // result checker, compares each word with the oldest expectation
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid) begin
            got = mk(o_status, o_woken_valid, o_woken_pid, o_resource_index,
                     o_available_after, o_last);
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = expected_words.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
                if (got.woken_valid != want.woken_valid)
                    report_mismatch($sformatf("woken_valid %0d want %0d",
                                              got.woken_valid, want.woken_valid));
                if (got.woken_pid != want.woken_pid)
                    report_mismatch($sformatf("woken_pid %0d want %0d",
                                              got.woken_pid, want.woken_pid));
                if (got.resource_index != want.resource_index)
                    report_mismatch($sformatf("resource_index %0d want %0d",
                                              got.resource_index, want.resource_index));
                if (got.available_after != want.available_after)
                    report_mismatch($sformatf("available_after %0d want %0d",
                                              got.available_after, want.available_after));
                if (got.last != want.last)
                    report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
            end
        end
    end

    initial begin
        fail_count = 0; idle_cycles = 0; timed_out = 1'b0;
        i_rst_n <= 1'b0; start <= 1'b0; i_mode <= rsm_pkg::MODE_WAIT; i_resource <= 3'd0;
        i_process_id <= 4'd0; psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= 5'd0; pwdata <= 32'd0;
        sem_count = rsm_pkg::RESET_RESOURCE_COUNT;
        for (int r = 0; r < NRES; r++) begin
            sem_avail[r] = (r == 0) ? rsm_pkg::RESET_UNITS_R0 : 8'd0;
            sem_head[r] = 3'd0; sem_fill[r] = 4'd0;
            for (int p = 0; p < NPROC; p++) sem_held[r][p] = 8'd0;
            for (int q = 0; q < QDEPTH; q++) sem_queue[r][q] = 4'd0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_queue_edges();
        test_saturation();
        configure(3'd4, 8'd2, 8'd1, 8'd0, 8'd3);
        test_random_mix(45);
        configure(3'd3, 8'd0, 8'd4, 8'd1, 8'd255);
        test_random_mix(45);
        wait_drained();

        if (fail_count == 0 && expected_words.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
